@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the zero-sum subarray finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/zss_pkg.sv @@
// Package: types and constants of the zero-sum subarray finder.
package zss_pkg;

    localparam int MAX_LEN_DEF = 256;
    localparam int SUM_W_DEF   = 24;
    localparam int ELEM_W      = 16;
    localparam int IDX_W       = 8;

    typedef enum logic [1:0] {
        STATUS_FOUND    = 2'd0,
        STATUS_NONE     = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element_value;
        logic                     is_last;
    } item_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] start_index;
        logic [IDX_W-1:0] end_index;
    } result_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic match;
        logic store;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic go_scan;
        logic found;
        logic scan_end;
        logic res_pend;
    } stat_t;

endpackage

@@ hw/rtl/zss_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module zss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/zss_ctrl.sv @@
// Controller: sequences load, table scan, finish and result hand-off.
`include "assert_macros.svh"

module zss_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    output logic           result_valid,
    input  logic           result_ready,
    input  zss_pkg::stat_t stat,
    output zss_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_POST
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign slot_free    = !out_valid_reg || result_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.go_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (stat.found)
                begin
                    cmd.match  = 1'b1;
                    state_next = S_FINISH;
                end
                else if (stat.scan_end)
                begin
                    cmd.store  = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (stat.res_pend)
                begin
                    if (slot_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = cmd.emit ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_IMPLY(a_emit_slot_free, clk, rst_n, cmd.emit, slot_free, "result overwritten")
    `ASSERT_ALWAYS(a_cmd_onehot, clk, rst_n,
        $onehot0({cmd.load, cmd.match, cmd.store, cmd.finish, cmd.emit}), "command clash")

endmodule

@@ hw/rtl/zss_dp.sv @@
// Datapath: prefix sum, prefix table, scan pipeline and result registers.
`include "assert_macros.svh"

module zss_dp #(
    parameter int MAX_LEN   = zss_pkg::MAX_LEN_DEF,
    parameter int SUM_WIDTH = zss_pkg::SUM_W_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  zss_pkg::cmd_t    cmd,
    input  zss_pkg::item_t   item,
    output zss_pkg::stat_t   stat,
    output zss_pkg::result_t result
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int EW = zss_pkg::ELEM_W;
    localparam int IW = zss_pkg::IDX_W;

    logic [SUM_WIDTH-1:0] sum_reg;
    logic [CW-1:0]        count_reg;
    logic                 match_done_reg;
    logic                 overflowed_reg;
    logic                 last_reg;
    logic [CW-1:0]        addr_reg;
    logic                 cmp_valid_reg;
    logic [CW-1:0]        cmp_idx_reg;
    logic                 res_pend_reg;
    zss_pkg::result_t     res_reg;
    zss_pkg::result_t     out_reg;

    logic [SUM_WIDTH-1:0] elem_ext;
    logic                 active;
    logic                 full;
    logic                 rd_en;
    logic [SUM_WIDTH-1:0] rd_data;
    logic                 zero_hit;
    logic                 tbl_hit;
    logic [CW-1:0]        start_cnt;
    logic [CW+IW-1:0]     start_wide;
    logic [CW+IW-1:0]     end_wide;

    assign elem_ext   = {{(SUM_WIDTH-EW){item.element_value[EW-1]}}, item.element_value};
    assign active     = !match_done_reg && !overflowed_reg;
    assign full       = (count_reg == CW'(MAX_LEN));
    assign rd_en      = cmd.scan && (addr_reg < count_reg);
    assign zero_hit   = (sum_reg == '0);
    assign tbl_hit    = cmp_valid_reg && (rd_data == sum_reg);
    assign start_cnt  = zero_hit ? '0 : (cmp_idx_reg + CW'(1));
    assign start_wide = {{IW{1'b0}}, start_cnt};
    assign end_wide   = {{IW{1'b0}}, count_reg};

    assign stat.go_scan  = active && !full;
    assign stat.found    = zero_hit || tbl_hit;
    assign stat.scan_end = !cmp_valid_reg && (addr_reg == count_reg);
    assign stat.res_pend = res_pend_reg;
    assign result        = out_reg;

    zss_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (MAX_LEN)
    ) u_table (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (count_reg[AW-1:0]),
        .wdata (sum_reg),
        .re    (rd_en),
        .raddr (addr_reg[AW-1:0]),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            count_reg      <= '0;
            match_done_reg <= 1'b0;
            overflowed_reg <= 1'b0;
            last_reg       <= 1'b0;
            addr_reg       <= '0;
            cmp_valid_reg  <= 1'b0;
            res_pend_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                last_reg      <= item.is_last;
                addr_reg      <= '0;
                cmp_valid_reg <= 1'b0;
                if (active && full)
                begin
                    overflowed_reg <= 1'b1;
                end
                else if (active)
                begin
                    sum_reg <= sum_reg + elem_ext;
                end
            end
            if (cmd.scan)
            begin
                cmp_valid_reg <= rd_en;
                if (rd_en)
                begin
                    addr_reg <= addr_reg + CW'(1);
                end
            end
            if (cmd.match)
            begin
                match_done_reg <= 1'b1;
                res_pend_reg   <= 1'b1;
            end
            if (cmd.store)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.finish && last_reg)
            begin
                if (!match_done_reg)
                begin
                    res_pend_reg <= 1'b1;
                end
                sum_reg        <= '0;
                count_reg      <= '0;
                match_done_reg <= 1'b0;
                overflowed_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                res_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            cmp_idx_reg <= addr_reg;
        end
        if (cmd.match)
        begin
            res_reg.status      <= zss_pkg::STATUS_FOUND;
            res_reg.start_index <= start_wide[IW-1:0];
            res_reg.end_index   <= end_wide[IW-1:0];
        end
        if (cmd.finish && last_reg && !match_done_reg)
        begin
            res_reg.status      <= overflowed_reg ? zss_pkg::STATUS_OVERFLOW
                                                  : zss_pkg::STATUS_NONE;
            res_reg.start_index <= '0;
            res_reg.end_index   <= '0;
        end
        if (cmd.emit)
        begin
            out_reg <= res_reg;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(MAX_LEN), "table count past depth")
    `ASSERT_ALWAYS(a_flags_excl, clk, rst_n, !(match_done_reg && overflowed_reg),
        "match and overflow both set")
    `ASSERT_IMPLY(a_load_no_pend, clk, rst_n, cmd.load, !res_pend_reg, "item taken with result pending")

endmodule

@@ hw/rtl/zero_sum_subarray_finder.sv @@
// After an item is accepted, item_ready stays low through the table scan, the finish state
// and the post state, so no new item is taken until the last one is through; the scan runs
// through the single read port of the prefix table, one entry a cycle, until a match or the end.
// A result is registered on the edge that raises item_ready again; an untaken result stalls.
// Reset (rst_n, async, active low) clears sum, count, flags and handshakes; the table is not
// cleared, entries are read only below the fill count.
module zero_sum_subarray_finder #(
    parameter int MAX_LEN   = zss_pkg::MAX_LEN_DEF,
    parameter int SUM_WIDTH = zss_pkg::SUM_W_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  zss_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output zss_pkg::result_t result
);

    zss_pkg::cmd_t  cmd;
    zss_pkg::stat_t stat;

    zss_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    zss_dp #(
        .MAX_LEN   (MAX_LEN),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .stat   (stat),
        .result (result)
    );

endmodule

@@ dv/zero_sum_subarray_finder_checker.sv @@
// Checker for the zero-sum subarray finder: predicts each report and compares it.
`timescale 1ns / 1ps

module zero_sum_subarray_finder_checker #(
    parameter int MAX_LEN   = zss_pkg::MAX_LEN_DEF,
    parameter int SUM_WIDTH = zss_pkg::SUM_W_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_ready,
    input  zss_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_ready,
    input  zss_pkg::result_t result,
    output int unsigned      fail_count,
    output int unsigned      awaited_count
);

    logic [SUM_WIDTH-1:0] running_total = '0;
    logic [SUM_WIDTH-1:0] sum_table [MAX_LEN];
    int unsigned          table_fill = 0;
    bit                   matched = 1'b0;
    bit                   overran = 1'b0;

    zss_pkg::result_t     awaited_reports [$];
    int unsigned          mismatches = 0;
    int unsigned          waiting = 0;

    assign fail_count    = mismatches;
    assign awaited_count = waiting;

    function automatic bit predict_report(input zss_pkg::item_t it,
                                          output zss_pkg::result_t rep);
        logic [SUM_WIDTH-1:0] addend;
        int unsigned          hit_at;
        int unsigned          k;
        bit                   hit;
        bit                   emit;
        hit    = 1'b0;
        hit_at = 0;
        emit   = 1'b0;
        rep    = '0;
        if (!matched && !overran)
        begin
            if (table_fill >= MAX_LEN)
            begin
                overran = 1'b1;
            end
            else
            begin
                addend = {{(SUM_WIDTH - zss_pkg::ELEM_W){it.element_value[zss_pkg::ELEM_W-1]}},
                          it.element_value};
                running_total = running_total + addend;
                if (running_total == '0)
                    hit = 1'b1;
                for (k = 0; k < table_fill && !hit; k++)
                begin
                    if (sum_table[k] == running_total)
                    begin
                        hit    = 1'b1;
                        hit_at = k + 1;
                    end
                end
                if (hit)
                begin
                    rep.status      = zss_pkg::STATUS_FOUND;
                    rep.start_index = hit_at[zss_pkg::IDX_W-1:0];
                    rep.end_index   = table_fill[zss_pkg::IDX_W-1:0];
                    matched         = 1'b1;
                    emit            = 1'b1;
                end
                else
                begin
                    sum_table[table_fill] = running_total;
                    table_fill++;
                end
            end
        end
        if (it.is_last)
        begin
            if (!matched)
            begin
                if (overran)
                    rep.status = zss_pkg::STATUS_OVERFLOW;
                else
                    rep.status = zss_pkg::STATUS_NONE;
                emit = 1'b1;
            end
            running_total = '0;
            table_fill    = 0;
            matched       = 1'b0;
            overran       = 1'b0;
        end
        return emit;
    endfunction

    always @(posedge clk)
    begin : watch
        zss_pkg::result_t predicted;
        zss_pkg::result_t want;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                if (predict_report(item, predicted))
                    awaited_reports = {awaited_reports, predicted};
            end
            if (result_valid && result_ready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $error("unexpected result transaction: status %0d start %0d end %0d",
                           result.status, result.start_index, result.end_index);
                    mismatches++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, result.status);
                        mismatches++;
                    end
                    if (result.start_index !== want.start_index)
                    begin
                        $error("start_index: expected %0d, actual %0d",
                               want.start_index, result.start_index);
                        mismatches++;
                    end
                    if (result.end_index !== want.end_index)
                    begin
                        $error("end_index: expected %0d, actual %0d",
                               want.end_index, result.end_index);
                        mismatches++;
                    end
                end
            end
            waiting <= awaited_reports.size();
        end
    end

endmodule

@@ dv/zero_sum_subarray_finder_tb.sv @@
// Testbench top for the zero-sum subarray finder: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module zero_sum_subarray_finder_tb;

    localparam int unsigned RANDOM_ITEMS    = 1000;
    localparam int unsigned MIN_ARRAYS      = 41;
    localparam int unsigned LONG_HOLD       = 400;
    localparam int unsigned WATCHDOG_CYCLES = 5000;
    localparam int unsigned SETTLE_CYCLES   = zss_pkg::MAX_LEN_DEF + 40;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_ready;
    zss_pkg::item_t   item = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    zss_pkg::result_t result;

    int unsigned      fail_count;
    int unsigned      awaited_count;
    int unsigned      sent_count = 0;
    int unsigned      quiet_cycles = 0;
    bit               sender_calm = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    zero_sum_subarray_finder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    zero_sum_subarray_finder_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .fail_count    (fail_count),
        .awaited_count (awaited_count)
    );

    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_elem(input int value, input bit last);
        int unsigned gap;
        item_valid         <= 1'b1;
        item.element_value <= 16'(value);
        item.is_last       <= last;
        do
            @(posedge clk);
        while (!item_ready);
        sent_count++;
        gap = sender_calm ? 0 : idle_span();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_count != 0);
    endtask

    // receiver: random stalls per transaction, calm stretches, two long hold-offs
    initial
    begin : rx_side
        int unsigned n_taken;
        int unsigned hold;
        bit          calm;
        n_taken = 0;
        calm    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                n_taken++;
                if ($urandom_range(0, 7) == 0)
                    calm = !calm;
                if (!calm || n_taken == 2 || n_taken == 25)
                    result_ready <= 1'b0;
            end
            else if (result_valid && !result_ready)
            begin
                hold = (n_taken == 2 || n_taken == 25) ? LONG_HOLD : idle_span();
                repeat (hold) @(posedge clk);
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $error("no transaction for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned n_arrays;
        int unsigned len;
        int unsigned style;
        int unsigned extra;
        int unsigned pick;
        int unsigned k;
        int          plant_at;
        int          plant_from;
        int          tail_sum;
        int          value;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single zero element: empty-prefix match on the last element
        send_elem(0, 1'b1);
        send_elem(5, 1'b1);
        send_elem(32767, 1'b0);
        send_elem(32767, 1'b1);
        send_elem(-32768, 1'b0);
        send_elem(32767, 1'b0);
        send_elem(1, 1'b1);
        // match against a stored sum, then the tail is swallowed
        send_elem(3, 1'b0);
        send_elem(7, 1'b0);
        send_elem(-7, 1'b0);
        send_elem(9, 1'b0);
        send_elem(-32768, 1'b1);
        send_elem(-1, 1'b0);
        send_elem(1, 1'b0);
        send_elem(4, 1'b1);
        send_elem(2, 1'b0);
        send_elem(-32768, 1'b0);
        send_elem(32767, 1'b0);
        send_elem(1, 1'b0);
        send_elem(-2, 1'b1);
        wait_drained();

        n_arrays = 0;
        while (sent_count < RANDOM_ITEMS || n_arrays < MIN_ARRAYS)
        begin
            sender_calm = ($urandom_range(0, 3) == 0);
            case (n_arrays)
                5:
                begin
                    // full table, strictly rising sums: no match
                    for (k = 0; k < 256; k++)
                        send_elem(int'($urandom_range(1, 32767)), k == 255);
                end
                20:
                begin
                    // match on the last table slot, then elements past the table size
                    pick  = $urandom_range(0, 254);
                    extra = $urandom_range(1, 10);
                    for (k = 0; k < 256 + extra; k++)
                    begin
                        if (k < 255)
                            value = 1;
                        else if (k == 255)
                            value = int'(pick) - 254;
                        else
                            value = int'($urandom_range(0, 65535)) - 32768;
                        send_elem(value, k == 255 + extra);
                    end
                end
                40:
                begin
                    extra = $urandom_range(1, 6);
                    for (k = 0; k < 256 + extra; k++)
                        send_elem(-32768, k == 255 + extra);
                end
                default:
                begin
                    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                        : $urandom_range(1, 12);
                    style = $urandom_range(0, 3);
                    plant_at   = (len > 1) ? int'($urandom_range(1, len - 1)) : int'(len);
                    plant_from = plant_at - int'($urandom_range(1, 30));
                    if (plant_from < 0)
                        plant_from = 0;
                    tail_sum = 0;
                    for (k = 0; k < len; k++)
                    begin
                        case (style)
                            0: value = int'($urandom_range(0, 8)) - 4;
                            1: value = int'($urandom_range(0, 65535)) - 32768;
                            2:
                            begin
                                case ($urandom_range(0, 4))
                                    0: value = 32767;
                                    1: value = -32768;
                                    2: value = -1;
                                    3: value = 1;
                                    default: value = int'($urandom_range(0, 65535)) - 32768;
                                endcase
                            end
                            default:
                            begin
                                // element that cancels a recent run of elements
                                if (int'(k) == plant_at)
                                    value = -tail_sum;
                                else
                                    value = int'($urandom_range(0, 2000)) - 1000;
                            end
                        endcase
                        if (int'(k) >= plant_from && int'(k) < plant_at)
                            tail_sum += value;
                        send_elem(value, k == len - 1);
                    end
                end
            endcase
            n_arrays++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_count != 0)
            $error("%0d expected transactions never arrived", awaited_count);
        if (fail_count == 0 && awaited_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
